>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the mean and variance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMV_ASSERT_IMP(lbl, ante, cons, msg)
`define SMV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/smv_pkg.sv
// Widths, step counts and parameter defaults of the mean and variance block.
package smv_pkg;

  localparam int SampleW       = 24;   // sample field
  localparam int CountW        = 17;   // element count
  localparam int SumW          = 41;   // running sum, signed
  localparam int TotalW        = 40;   // total field
  localparam int SqW           = 47;   // square of one sample
  localparam int SumSqW        = 63;   // running sum of squares
  localparam int MagW          = 40;   // magnitude of the sum
  localparam int WideW         = 80;   // shared adder and numerator
  localparam int DvsW          = 2 * CountW;  // n squared
  localparam int VarW          = 47;   // variance field
  localparam int VarPadW       = 48;   // variance padded to whole bit pairs
  localparam int RootW         = VarPadW / 2;
  localparam int StepW         = 7;    // iteration counter, holds WideW - 1

  localparam int MulQSteps     = CountW;
  localparam int SqsSteps      = MagW;
  localparam int N2Steps       = CountW;
  localparam int DivSteps      = WideW;
  localparam int MeanSteps     = MagW;
  localparam int SqrtSteps     = RootW;

  localparam int MaxLenDef     = 65536;
  localparam int SampleBitsDef = 24;

endpackage

>>> hw/rtl/smv_stream_if.sv
// Valid/ready stream interfaces for the sample and result channels.
interface smv_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [smv_pkg::SampleW-1:0]  sample;
  logic                                last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface smv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [smv_pkg::TotalW-1:0]   total;
  logic signed [smv_pkg::SampleW-1:0]  average;
  logic        [smv_pkg::VarW-1:0]     spread_squared;
  logic        [smv_pkg::RootW-1:0]    spread;
  logic        [smv_pkg::CountW-1:0]   element_count;
  logic                                too_long;

  modport source (output valid, total, average, spread_squared, spread, element_count,
                  too_long, input ready);
  modport sink   (input valid, total, average, spread_squared, spread, element_count,
                  too_long, output ready);
endinterface

>>> hw/rtl/streaming_mean_variance.sv
// Streaming population mean, variance and standard deviation over a sample vector.
//
// Samples arrive on in_ch, one item per cycle while a vector runs: each sample is
// squared by one 24x24 multiplier, and the square is registered and added to the sum
// of squares in the next cycle, so a vector streams in at full rate. The item carrying
// last closes the vector; ready then stays low while a single 80-bit adder/subtractor,
// stepped by a small sequencer, works out the statistics one bit per cycle: it drains
// the pending square, then forms n * sum_of_squares and sum^2, subtracts, forms n^2,
// and runs the variance division, the mean division, the square root and the load of
// the result register. The 80-step restoring division dominates. The result item
// appears on out_ch once the result register is loaded; if the previous result still
// waits there, the block holds in its final step until it is taken. Samples past
// MAX_LEN are dropped and flagged in too_long; only the low SAMPLE_BITS bits of a
// sample are used, sign-extended. The average truncates toward zero, the variance is
// floor((n*sumsq - sum^2) / n^2) and spread is its integer square root.

`include "assert_macros.svh"

module streaming_mean_variance #(
  parameter int MAX_LEN     = smv_pkg::MaxLenDef,
  parameter int SAMPLE_BITS = smv_pkg::SampleBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  smv_in_if.sink            in_ch,
  smv_out_if.source         out_ch
);

  localparam int ExtShift = smv_pkg::SampleW - SAMPLE_BITS;

  typedef enum logic [3:0] {
    ST_ACC,    // take samples
    ST_DRAIN,  // fold in the last pending square
    ST_MULQ,   // n * sum of squares
    ST_SQS,    // sum squared
    ST_SUB,    // numerator = n*sumsq - sum^2
    ST_N2,     // n squared
    ST_DIV,    // numerator / n^2
    ST_MEAN,   // |sum| / n
    ST_SQRT,   // integer square root of the variance
    ST_FIN     // load the result register
  } state_t;

  // Control state
  state_t                              state_r, state_nxt;
  logic [smv_pkg::CountW-1:0]          count_r, count_nxt;
  logic signed [smv_pkg::SumW-1:0]     sum_r, sum_nxt;
  logic [smv_pkg::SumSqW-1:0]          sumsq_r, sumsq_nxt;
  logic                                ovf_r, ovf_nxt;
  logic                                sqv_r, sqv_nxt;
  logic                                out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [smv_pkg::SqW-1:0]             sq_r, sq_nxt;
  logic [smv_pkg::StepW-1:0]           cnt_r, cnt_nxt;
  logic [smv_pkg::WideW-1:0]           acc_r, acc_nxt;
  logic [smv_pkg::WideW-1:0]           num_r, num_nxt;
  logic [smv_pkg::MagW-1:0]            mpl_r, mpl_nxt;
  logic [smv_pkg::MagW-1:0]            mag_r, mag_nxt;
  logic [smv_pkg::DvsW-1:0]            dvs_r, dvs_nxt;
  logic [smv_pkg::RootW-1:0]           root_r, root_nxt;

  // Result register
  logic signed [smv_pkg::TotalW-1:0]   total_r, total_nxt;
  logic signed [smv_pkg::SampleW-1:0]  avg_r, avg_nxt;
  logic [smv_pkg::VarW-1:0]            var_r, var_nxt;
  logic [smv_pkg::RootW-1:0]           spread_r, spread_nxt;
  logic [smv_pkg::CountW-1:0]          n_out_r, n_out_nxt;
  logic                                too_long_r, too_long_nxt;

  // Shared adder/subtractor
  logic [smv_pkg::WideW-1:0]           alu_a, alu_b;
  logic                                alu_sub;
  logic [smv_pkg::WideW:0]             alu_res;
  logic                                alu_ge;

  logic                                in_acc;
  logic signed [smv_pkg::SampleW-1:0]  samp_shl, samp_ext;
  logic signed [2*smv_pkg::SampleW-1:0] sq_full;
  logic signed [smv_pkg::SumW-1:0]     sum_abs;
  logic [smv_pkg::SampleW-1:0]         avg_mag;
  logic                                step_end;

  assign in_ch.ready  = (state_r == ST_ACC);
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Sign-extend from bit SAMPLE_BITS-1, dropping bits above it
  assign samp_shl = in_ch.sample << ExtShift;
  assign samp_ext = samp_shl >>> ExtShift;
  assign sq_full  = samp_ext * samp_ext;

  assign sum_abs  = sum_r[smv_pkg::SumW-1] ? -sum_r : sum_r;
  assign avg_mag  = mag_r[smv_pkg::SampleW-1:0];
  assign step_end = (cnt_r == '0);

  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (smv_pkg::WideW + 1)'(alu_sub);
  assign alu_ge  = alu_res[smv_pkg::WideW];

  // Operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_MULQ: begin
        alu_a = {acc_r[smv_pkg::WideW-2:0], 1'b0};
        alu_b = mpl_r[smv_pkg::MagW-1] ? smv_pkg::WideW'(sumsq_r) : '0;
      end
      ST_SQS: begin
        alu_a = {acc_r[smv_pkg::WideW-2:0], 1'b0};
        alu_b = mpl_r[smv_pkg::MagW-1] ? smv_pkg::WideW'(mag_r) : '0;
      end
      ST_SUB: begin
        alu_a   = num_r;
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      ST_N2: begin
        alu_a = {acc_r[smv_pkg::WideW-2:0], 1'b0};
        alu_b = mpl_r[smv_pkg::MagW-1] ? smv_pkg::WideW'(count_r) : '0;
      end
      ST_DIV: begin
        alu_a   = {acc_r[smv_pkg::WideW-2:0], num_r[smv_pkg::WideW-1]};
        alu_b   = smv_pkg::WideW'(dvs_r);
        alu_sub = 1'b1;
      end
      ST_MEAN: begin
        alu_a   = {acc_r[smv_pkg::WideW-2:0], mag_r[smv_pkg::MagW-1]};
        alu_b   = smv_pkg::WideW'(count_r);
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = {acc_r[smv_pkg::WideW-3:0], num_r[smv_pkg::VarPadW-1 -: 2]};
        alu_b   = smv_pkg::WideW'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    ovf_nxt       = ovf_r;
    sqv_nxt       = 1'b0;
    out_valid_nxt = out_valid_r;
    sq_nxt        = sq_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    mpl_nxt       = mpl_r;
    mag_nxt       = mag_r;
    dvs_nxt       = dvs_r;
    root_nxt      = root_r;
    total_nxt     = total_r;
    avg_nxt       = avg_r;
    var_nxt       = var_r;
    spread_nxt    = spread_r;
    n_out_nxt     = n_out_r;
    too_long_nxt  = too_long_r;

    // Fold the square registered last cycle into the running sum of squares
    if (sqv_r) begin
      sumsq_nxt = sumsq_r + smv_pkg::SumSqW'(sq_r);
    end

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_ACC: begin
        if (in_acc) begin
          if (count_r < smv_pkg::CountW'(MAX_LEN)) begin
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_r + smv_pkg::SumW'(samp_ext);
            sq_nxt    = sq_full[smv_pkg::SqW-1:0];
            sqv_nxt   = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        mag_nxt   = sum_abs[smv_pkg::MagW-1:0];
        mpl_nxt   = {count_r, {(smv_pkg::MagW - smv_pkg::CountW){1'b0}}};
        acc_nxt   = '0;
        cnt_nxt   = smv_pkg::StepW'(smv_pkg::MulQSteps - 1);
        state_nxt = ST_MULQ;
      end
      ST_MULQ: begin
        acc_nxt = alu_res[smv_pkg::WideW-1:0];
        mpl_nxt = {mpl_r[smv_pkg::MagW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (step_end) begin
          num_nxt   = alu_res[smv_pkg::WideW-1:0];
          acc_nxt   = '0;
          mpl_nxt   = mag_r;
          cnt_nxt   = smv_pkg::StepW'(smv_pkg::SqsSteps - 1);
          state_nxt = ST_SQS;
        end
      end
      ST_SQS: begin
        acc_nxt = alu_res[smv_pkg::WideW-1:0];
        mpl_nxt = {mpl_r[smv_pkg::MagW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (step_end) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        num_nxt   = alu_res[smv_pkg::WideW-1:0];
        acc_nxt   = '0;
        mpl_nxt   = {count_r, {(smv_pkg::MagW - smv_pkg::CountW){1'b0}}};
        cnt_nxt   = smv_pkg::StepW'(smv_pkg::N2Steps - 1);
        state_nxt = ST_N2;
      end
      ST_N2: begin
        acc_nxt = alu_res[smv_pkg::WideW-1:0];
        mpl_nxt = {mpl_r[smv_pkg::MagW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (step_end) begin
          dvs_nxt   = alu_res[smv_pkg::DvsW-1:0];
          acc_nxt   = '0;
          cnt_nxt   = smv_pkg::StepW'(smv_pkg::DivSteps - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division: remainder in acc, quotient shifts into num
        acc_nxt = alu_ge ? alu_res[smv_pkg::WideW-1:0] : alu_a;
        num_nxt = {num_r[smv_pkg::WideW-2:0], alu_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (step_end) begin
          acc_nxt   = '0;
          cnt_nxt   = smv_pkg::StepW'(smv_pkg::MeanSteps - 1);
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        acc_nxt = alu_ge ? alu_res[smv_pkg::WideW-1:0] : alu_a;
        mag_nxt = {mag_r[smv_pkg::MagW-2:0], alu_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (step_end) begin
          acc_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = smv_pkg::StepW'(smv_pkg::SqrtSteps - 1);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // Two bits a step; rotate the variance so it is intact at the end
        acc_nxt  = alu_ge ? alu_res[smv_pkg::WideW-1:0] : alu_a;
        root_nxt = {root_r[smv_pkg::RootW-2:0], alu_ge};
        num_nxt  = {num_r[smv_pkg::WideW-1:smv_pkg::VarPadW],
                    num_r[smv_pkg::VarPadW-3:0], num_r[smv_pkg::VarPadW-1 -: 2]};
        cnt_nxt  = cnt_r - 1'b1;
        if (step_end) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          total_nxt     = sum_r[smv_pkg::TotalW-1:0];
          avg_nxt       = sum_r[smv_pkg::SumW-1] ? -$signed(avg_mag) : $signed(avg_mag);
          var_nxt       = num_r[smv_pkg::VarW-1:0];
          spread_nxt    = root_r;
          n_out_nxt     = count_r;
          too_long_nxt  = ovf_r;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          sum_nxt       = '0;
          sumsq_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sq_r       <= sq_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    num_r      <= num_nxt;
    mpl_r      <= mpl_nxt;
    mag_r      <= mag_nxt;
    dvs_r      <= dvs_nxt;
    root_r     <= root_nxt;
    total_r    <= total_nxt;
    avg_r      <= avg_nxt;
    var_r      <= var_nxt;
    spread_r   <= spread_nxt;
    n_out_r    <= n_out_nxt;
    too_long_r <= too_long_nxt;
    if (!rst_n) begin
      state_r     <= ST_ACC;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      ovf_r       <= 1'b0;
      sqv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      ovf_r       <= ovf_nxt;
      sqv_r       <= sqv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.total          = total_r;
  assign out_ch.average        = avg_r;
  assign out_ch.spread_squared = var_r;
  assign out_ch.spread         = spread_r;
  assign out_ch.element_count  = n_out_r;
  assign out_ch.too_long       = too_long_r;

  // A closing item stalls the input while the statistics are worked out
  `SMV_ASSERT_NEXT(a_last_stalls, in_acc && in_ch.last, !in_ch.ready, "ready after last item")
  // A sample past the length limit must raise the overflow flag
  `SMV_ASSERT_NEXT(a_ovf_set, in_acc && (count_r == smv_pkg::CountW'(MAX_LEN)), ovf_r,
                   "overflow flag missed")
  // No square may still be pending once the products start
  `SMV_ASSERT_IMP(a_sq_drained, state_r == ST_MULQ, !sqv_r, "square still pending")
  // Bits above the rotated variance window stay clear during the root extraction
  `SMV_ASSERT_IMP(a_var_fits, state_r == ST_SQRT,
                  num_r[smv_pkg::WideW-1:smv_pkg::VarPadW] == '0, "variance too wide")
  // Loading a result clears the accumulators and presents the item
  `SMV_ASSERT_NEXT(a_fin_load, (state_r == ST_FIN) && (!out_valid_r || out_ch.ready),
                   out_ch.valid && (count_r == '0) && in_ch.ready, "result load failed")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for streaming_mean_variance: directed table, then a random stream.
module tb_top;

  // Vector length limit and sample width follow the block's defaults.
  localparam int VecMax       = smv_pkg::MaxLenDef;
  localparam int RandomItems  = 1800;
  localparam int HoldOff      = 1200;  // long receiver stall
  localparam int IdleLimit    = 4000;  // cycles with no item moving on either channel
  localparam int DrainCycles  = 250;   // wait after the last owed result
  localparam int PressureAt   = 20;    // results seen before the long stall starts

  // One result item as the block reports it.
  typedef struct packed {
    logic signed [smv_pkg::TotalW-1:0]  total;
    logic signed [smv_pkg::SampleW-1:0] average;
    logic        [smv_pkg::VarW-1:0]    spread_squared;
    logic        [smv_pkg::RootW-1:0]   spread;
    logic        [smv_pkg::CountW-1:0]  element_count;
    logic                               too_long;
  } stats_t;

  // One row of the directed table; typed expectation only where golden is set.
  typedef struct packed {
    logic signed [smv_pkg::SampleW-1:0] sample;
    logic                               last;
    logic                               golden;
    stats_t                             exp;
  } row_t;

  // Value mixes for random vectors.
  typedef enum int {MixFull, MixSmall, MixEdge, MixCluster} sample_mix_t;

  localparam stats_t NoStats = '0;

  // Extremes, truncation toward zero, alternating bit patterns, one- to four-sample vectors.
  localparam row_t DIRECTED [25] = '{
    // empty state after reset
    '{24'sh000000, 1'b1, 1'b1, '{40'sd0, 24'sd0, 47'd0, 24'd0, 17'd1, 1'b0}},
    '{24'sh800000, 1'b1, 1'b1, '{-40'sd8388608, 24'sh800000, 47'd0, 24'd0, 17'd1, 1'b0}},
    '{24'sh7FFFFF, 1'b1, 1'b1, '{40'sd8388607, 24'sh7FFFFF, 47'd0, 24'd0, 17'd1, 1'b0}},
    '{24'sh800000, 1'b0, 1'b0, NoStats},
    // widest spread
    '{24'sh7FFFFF, 1'b1, 1'b1,
      '{-40'sd1, 24'sd0, 47'd70368735789056, 24'd8388607, 17'd2, 1'b0}},
    '{24'sh7FFFFF, 1'b0, 1'b0, NoStats},
    '{24'sh7FFFFF, 1'b1, 1'b1, '{40'sd16777214, 24'sh7FFFFF, 47'd0, 24'd0, 17'd2, 1'b0}},
    '{24'sh800000, 1'b0, 1'b0, NoStats},
    '{24'sh800000, 1'b0, 1'b0, NoStats},
    '{24'sh800000, 1'b1, 1'b1, '{-40'sd25165824, 24'sh800000, 47'd0, 24'd0, 17'd3, 1'b0}},
    '{-24'sd1,     1'b0, 1'b0, NoStats},
    '{-24'sd2,     1'b1, 1'b0, NoStats},                               // negative mean truncates
    '{24'sd3,      1'b0, 1'b0, NoStats},
    '{24'sd5,      1'b0, 1'b0, NoStats},
    '{24'sd10,     1'b1, 1'b0, NoStats},
    '{24'sh555555, 1'b0, 1'b0, NoStats},
    '{24'shAAAAAA, 1'b0, 1'b0, NoStats},
    '{24'sd1,      1'b1, 1'b0, NoStats},
    '{-24'sd7,     1'b0, 1'b0, NoStats},
    '{24'sd7,      1'b0, 1'b0, NoStats},
    '{24'sd0,      1'b0, 1'b0, NoStats},
    '{24'sd100,    1'b1, 1'b0, NoStats},
    '{24'sh7FFFFF, 1'b0, 1'b0, NoStats},
    '{24'sh800000, 1'b0, 1'b0, NoStats},
    '{24'sd1,      1'b1, 1'b0, NoStats}
  };

  logic clk = 1'b0;
  logic rst_n;

  smv_in_if  in_ch ();
  smv_out_if out_ch ();

  streaming_mean_variance uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Running statistics of the vector in flight, as the block should hold them.
  int unsigned       acc_count;
  longint            acc_sum;
  longint unsigned   acc_sqsum;
  bit                acc_dropped;

  stats_t            stats_due[$];   // results owed by the block, oldest first
  stats_t            want_stats;
  int                mismatch_count;
  int                results_seen;
  int                idle_cycles;
  int                gap_pct;        // chance of a sender gap before an item
  int                stall_pct;      // chance of a receiver stall burst
  bit                calm;           // no idling on either side
  bit                squeezed;       // long receiver stall already done

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Fold one accepted sample into the running statistics; on last, close the
  // vector, hand back the result it must produce and clear the state.
  function automatic bit absorb_sample(input logic signed [smv_pkg::SampleW-1:0] smp,
                                       input logic lst, output stats_t res);
    longint          s;
    longint          mag;
    longint          avg;
    bit [127:0]      numer;
    bit [127:0]      denom;
    bit [127:0]      quot;
    longint unsigned root;
    s   = smp;
    res = '0;
    // Past the length limit, drop the sample but remember that one was lost.
    if (acc_count < VecMax) begin
      acc_count++;
      acc_sum   += s;
      acc_sqsum += longint'(s * s);
    end else begin
      acc_dropped = 1'b1;
    end
    if (!lst) return 1'b0;
    mag   = (acc_sum < 0) ? -acc_sum : acc_sum;
    numer = 128'(acc_sqsum) * 128'(acc_count) - 128'(mag) * 128'(mag);
    denom = 128'(acc_count) * 128'(acc_count);
    quot  = numer / denom;
    root  = int_root(quot[63:0]);
    avg   = acc_sum / longint'(acc_count);
    res.total          = acc_sum[smv_pkg::TotalW-1:0];
    res.average        = avg[smv_pkg::SampleW-1:0];
    res.spread_squared = quot[smv_pkg::VarW-1:0];
    res.spread         = root[smv_pkg::RootW-1:0];
    res.element_count  = acc_count[smv_pkg::CountW-1:0];
    res.too_long       = acc_dropped;
    acc_count   = 0;
    acc_sum     = 0;
    acc_sqsum   = 0;
    acc_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [smv_pkg::SampleW-1:0] draw_sample(input sample_mix_t mix,
                                                                     input int center);
    int unsigned u;
    int          v;
    u = $urandom();
    case (mix)
      MixSmall: v = int'($urandom_range(0, 32)) - 16;
      MixEdge: begin
        case ($urandom_range(0, 4))
          0:       v = -8388608;
          1:       v = 8388607;
          2:       v = -1;
          3:       v = 1;
          default: v = 0;
        endcase
      end
      MixCluster: begin
        // Large mean with tiny spread stresses the subtraction of near-equal terms.
        v = center + int'($urandom_range(0, 8)) - 4;
        if (v > 8388607)  v = 8388607;
        if (v < -8388608) v = -8388608;
      end
      default: v = int'(u[smv_pkg::SampleW-1:0]);
    endcase
    return v[smv_pkg::SampleW-1:0];
  endfunction

  // Offer one item, with an optional gap in front; hold it until it is taken.
  // Called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_sample(input logic signed [smv_pkg::SampleW-1:0] smp, input logic lst,
                             input bit golden = 1'b0, input stats_t typed = '0);
    stats_t pred;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    in_ch.last   <= lst;
    do @(posedge clk); while (!in_ch.ready);
    if (absorb_sample(smp, lst, pred)) stats_due.push_back(golden ? typed : pred);
    @(negedge clk);
  endtask

  function automatic void check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted result with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        $error("result item arrived with none expected");
        mismatch_count++;
      end else begin
        want_stats = stats_due.pop_front();
        check_field("total", longint'(want_stats.total), longint'(out_ch.total));
        check_field("average", longint'(want_stats.average), longint'(out_ch.average));
        check_field("spread_squared", longint'(want_stats.spread_squared),
                    longint'(out_ch.spread_squared));
        check_field("spread", longint'(want_stats.spread), longint'(out_ch.spread));
        check_field("element_count", longint'(want_stats.element_count),
                    longint'(out_ch.element_count));
        check_field("too_long", longint'(want_stats.too_long), longint'(out_ch.too_long));
      end
    end
  end

  // Abort when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Receiver: bursts of back-pressure at a rate redrawn at random now and again,
  // plus one long hold-off so the block fills up and stalls its input.
  initial begin
    int rx_ticks;
    rx_ticks  = 0;
    stall_pct = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(negedge clk);
      rx_ticks++;
      if (rx_ticks % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (!squeezed && !calm && results_seen >= PressureAt) begin
        squeezed = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldOff) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Sender: reset, directed table, then random vectors.
  initial begin
    int          sent;
    int          vec_len;
    int          center;
    int          pick;
    sample_mix_t mix;
    acc_count   = 0;
    acc_sum     = 0;
    acc_sqsum   = 0;
    acc_dropped = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    calm     = 1'b0;
    squeezed = 1'b0;
    gap_pct  = 30;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last   <= 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the table; golden rows carry their own expectation.
    foreach (DIRECTED[i])
      send_sample(DIRECTED[i].sample, DIRECTED[i].last, DIRECTED[i].golden, DIRECTED[i].exp);

    // Random vectors, mostly short; idling stops for the final stretch.
    sent = 0;
    while (sent < RandomItems) begin
      calm = (sent >= RandomItems * 85 / 100);
      pick = $urandom_range(0, 9);
      if (pick < 7)      vec_len = $urandom_range(1, 8);
      else if (pick < 9) vec_len = $urandom_range(9, 64);
      else               vec_len = $urandom_range(65, 300);
      mix    = sample_mix_t'($urandom_range(0, 3));
      center = int'($urandom_range(0, 16777215)) - 8388608;
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        default: gap_pct = 25;
      endcase
      for (int k = 0; k < vec_len; k++)
        send_sample(draw_sample(mix, center), k == vec_len - 1);
      sent += vec_len;
    end
    in_ch.valid <= 1'b0;

    // Drain what is owed, then give the block time to show any extra result.
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
